// ----- src/mlac_pkg.sv -----
// shared constants, request codes and beat types of the multi-lag count autocorrelator
package mlac_pkg;

	// number of accumulated lags (lag 1 up to NUM_LAGS)
	localparam int NUM_LAGS = 5;

	// address width of the per-lag stores
	localparam int LAG_AW = (NUM_LAGS > 1) ? $clog2(NUM_LAGS) : 1;
	// width wide enough for both the lag field and the lag count itself
	localparam int IDX_W = ($clog2(NUM_LAGS + 1) > 3) ? $clog2(NUM_LAGS + 1) : 3;

	// field widths
	localparam int REQ_W    = 2;
	localparam int SAMPLE_W = 16;
	localparam int LAG_W    = 3;
	localparam int ACC_W    = 64;
	localparam int PROD_W   = 2 * SAMPLE_W;

	// stream widths, padded to whole bytes
	localparam int S_TDATA_W = ((SAMPLE_W + LAG_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((LAG_W + ACC_W + 7) / 8) * 8;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// request handed to the core
	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [SAMPLE_W-1:0] sample;
		logic [LAG_W-1:0]    lag_index;
	} cmd_t;

	// read result from the core
	typedef struct packed {
		logic [LAG_W-1:0] lag_index_out;
		logic [ACC_W-1:0] accum_value;
	} res_t;

endpackage

// ----- src/mlac_core.sv -----
// sample history, lag accumulators and the shared multiply-accumulate sequencer
module mlac_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  mlac_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output mlac_pkg::res_t res
);
	import mlac_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_DRAIN = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	localparam logic [LAG_AW-1:0] LAST_LAG = LAG_AW'(NUM_LAGS - 1);

	state_t state_q;

	// sequencer registers
	logic [LAG_AW-1:0]   pos_q;
	logic [LAG_AW-1:0]   slot_q;
	logic [LAG_AW-1:0]   lag_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [LAG_W-1:0]    rd_lag_q;
	logic                rd_in_range_q;

	// stores and their valid bits (an entry that is not valid reads as zero)
	logic [SAMPLE_W-1:0] hist_mem [NUM_LAGS];
	logic [ACC_W-1:0]    acc_mem  [NUM_LAGS];
	logic [NUM_LAGS-1:0] hist_vld_q;
	logic [NUM_LAGS-1:0] acc_vld_q;

	// pipeline: read, multiply, accumulate
	logic                v_s1;
	logic [LAG_AW-1:0]   addr_s1;
	logic [SAMPLE_W-1:0] hist_rd_s1;
	logic                hist_vld_s1;
	logic [ACC_W-1:0]    acc_rd_s1;
	logic                acc_vld_s1;
	logic                v_s2;
	logic [LAG_AW-1:0]   addr_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [ACC_W-1:0]    acc_s2;

	logic [IDX_W-1:0]    cmd_lag;
	logic                cmd_in_range;
	logic [LAG_AW-1:0]   cmd_addr;
	logic                accept;
	logic                issue;
	logic                rd_req;
	logic                clr;
	logic                acc_ren;
	logic [LAG_AW-1:0]   acc_raddr;
	logic                acc_wen;
	logic                hist_wen;
	logic [LAG_AW-1:0]   pos_prev;
	logic [LAG_AW-1:0]   pos_next;
	logic [LAG_AW-1:0]   slot_prev;
	logic [SAMPLE_W-1:0] hist_op;

	// request decode and address selection
	always_comb begin
		cmd_lag      = IDX_W'(cmd.lag_index);
		cmd_in_range = cmd_lag < IDX_W'(NUM_LAGS);
		cmd_addr     = cmd_in_range ? cmd_lag[LAG_AW-1:0] : '0;
		accept       = cmd_valid && (state_q == S_IDLE);
		issue        = (state_q == S_ISSUE);
		rd_req       = accept && (cmd.req_type == REQ_READ);
		clr          = accept && (cmd.req_type == REQ_CLEAR);
		acc_ren      = issue || rd_req;
		acc_raddr    = issue ? lag_q : cmd_addr;
		acc_wen      = v_s2;
		hist_wen     = (state_q == S_DRAIN) && !v_s1 && !v_s2;
		pos_prev     = (pos_q == '0) ? LAST_LAG : pos_q - 1'b1;
		pos_next     = (pos_q == LAST_LAG) ? '0 : pos_q + 1'b1;
		slot_prev    = (slot_q == '0) ? LAST_LAG : slot_q - 1'b1;
		hist_op      = hist_vld_s1 ? hist_rd_s1 : '0;
	end

	// store ports
	always_ff @(posedge clk) begin
		if (acc_wen) begin
			acc_mem[addr_s2] <= acc_s2 + ACC_W'(prod_s2);
		end
		if (acc_ren) begin
			acc_rd_s1 <= acc_mem[acc_raddr];
		end
		if (hist_wen) begin
			hist_mem[pos_q] <= sample_q;
		end
		if (issue) begin
			hist_rd_s1 <= hist_mem[slot_q];
		end
	end

	// valid bits of the stores, cleared together by reset or a clear request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			acc_vld_q  <= '0;
		end else if (clr) begin
			hist_vld_q <= '0;
			acc_vld_q  <= '0;
		end else begin
			if (acc_wen) begin
				acc_vld_q[addr_s2] <= 1'b1;
			end
			if (hist_wen) begin
				hist_vld_q[pos_q] <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc_ren) begin
			acc_vld_s1 <= acc_vld_q[acc_raddr];
		end
		if (issue) begin
			hist_vld_s1 <= hist_vld_q[slot_q];
			addr_s1     <= lag_q;
		end
		if (v_s1) begin
			prod_s2 <= PROD_W'(hist_op) * PROD_W'(sample_q);
			acc_s2  <= acc_vld_s1 ? acc_rd_s1 : '0;
			addr_s2 <= addr_s1;
		end
		if (accept) begin
			sample_q      <= cmd.sample;
			rd_lag_q      <= cmd.lag_index;
			rd_in_range_q <= cmd_in_range;
		end
	end

	// pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			slot_q  <= '0;
			lag_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.req_type)
							REQ_PUSH: begin
								lag_q   <= '0;
								slot_q  <= pos_prev;
								state_q <= S_ISSUE;
							end
							REQ_READ: begin
								state_q <= S_RESP;
							end
							REQ_CLEAR: begin
								pos_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_ISSUE: begin
					lag_q  <= lag_q + 1'b1;
					slot_q <= slot_prev;
					if (lag_q == LAST_LAG) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (hist_wen) begin
						pos_q   <= pos_next;
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// handshake and result
	always_comb begin
		cmd_ready         = (state_q == S_IDLE);
		res_valid         = (state_q == S_RESP);
		res.lag_index_out = rd_lag_q;
		res.accum_value   = (rd_in_range_q && acc_vld_s1) ? acc_rd_s1 : '0;
	end

endmodule

// ----- src/multi_lag_count_autocorrelator.sv -----
// top level of the multi-lag count autocorrelator with stream ports and output register
//
// Running autocorrelator over 16-bit count samples. A push beat multiplies the new
// sample by each of the NUM_LAGS previous samples and adds the products to one
// 64-bit wrapping accumulator per lag; a read beat returns the accumulator of lag
// lag_index+1 (zero when that lag does not exist); a clear beat zeroes samples,
// accumulators and write position. Only read beats produce an output beat. All
// lag work goes through one 16x16 multiplier and one 64-bit adder, fed from the
// history and accumulator stores one lag per cycle, so a push holds the input
// through store read, multiply and accumulate of every lag and the history
// write. A read holds it until the output register takes the result. s_tready
// is low while a request is in progress.
module multi_lag_count_autocorrelator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// sample [15:0], lag_index [18:16], zero pad
	input  logic [mlac_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type [1:0]
	input  logic [mlac_pkg::REQ_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// lag_index_out [2:0], accum_value [66:3], zero pad
	output logic [mlac_pkg::M_TDATA_W-1:0] m_tdata
);
	import mlac_pkg::*;

	cmd_t cmd;
	res_t core_res;
	logic core_res_valid;
	logic core_res_ready;
	logic out_valid_q;
	res_t out_q;

	// unpack the input beat
	always_comb begin
		cmd.req_type  = s_tuser;
		cmd.sample    = s_tdata[SAMPLE_W-1:0];
		cmd.lag_index = s_tdata[SAMPLE_W +: LAG_W];
	end

	mlac_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.res_valid (core_res_valid),
		.res_ready (core_res_ready),
		.res       (core_res)
	);

	// output register
	assign core_res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_ready) begin
			out_valid_q <= core_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid && core_res_ready) begin
			out_q <= core_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_q.accum_value, out_q.lag_index_out});

	// push, clear and spare-code beats never lead to a result in the next cycle
	a_no_res_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser != REQ_READ)) |=> !core_res_valid)
		else $error("result after a push or clear beat");

	// the block is busy right after taking a read
	a_busy_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == REQ_READ)) |=> !s_tready)
		else $error("ready right after a read beat");

	// an output beat appears only from a core result
	a_out_from_core: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(core_res_valid))
		else $error("output beat without a core result");

	// a lag that does not exist reads as zero
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (IDX_W'(m_tdata[LAG_W-1:0]) >= IDX_W'(NUM_LAGS)))
		|-> (m_tdata[LAG_W +: ACC_W] == '0))
		else $error("nonzero value for a lag out of range");

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the multi-lag count autocorrelator
`timescale 1ns / 1ps

module testbench;
	import mlac_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic [REQ_W-1:0]       s_tuser = REQ_PUSH;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;

	// shadow copy of the correlator state
	logic [SAMPLE_W-1:0]    shadow_hist [NUM_LAGS];
	logic [ACC_W-1:0]       shadow_acc [NUM_LAGS];
	int unsigned            shadow_wpos;

	// read results still owed by the block, oldest first
	res_t                   pending_reads [$];
	int                     mismatch_count = 0;
	int                     src_idle_pct = 0;
	int                     sink_idle_pct = 0;

	multi_lag_count_autocorrelator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// zero samples, accumulators and position
	function automatic void shadow_clear();
		for (int k = 0; k < NUM_LAGS; k++) begin
			shadow_hist[k] = '0;
			shadow_acc[k] = '0;
		end
		shadow_wpos = 0;
	endfunction

	// update the shadow state for one accepted request, queue any read result
	function automatic void shadow_step(input logic [REQ_W-1:0] req,
			input logic [SAMPLE_W-1:0] smp, input logic [LAG_W-1:0] lag);
		res_t        want;
		int unsigned slot;
		case (req)
			REQ_PUSH: begin
				for (int unsigned l = 1; l <= NUM_LAGS; l++) begin
					slot = (shadow_wpos + NUM_LAGS - l) % NUM_LAGS;
					shadow_acc[l-1] += ACC_W'(shadow_hist[slot]) * ACC_W'(smp);
				end
				shadow_hist[shadow_wpos] = smp;
				shadow_wpos = (shadow_wpos + 1) % NUM_LAGS;
			end
			REQ_READ: begin
				want.lag_index_out = lag;
				want.accum_value = (lag < NUM_LAGS) ? shadow_acc[lag] : '0;
				pending_reads.push_back(want);
			end
			REQ_CLEAR: shadow_clear();
			default: ;
		endcase
	endfunction

	// drive one request beat, idling first at random, and wait for acceptance
	task automatic send_beat(input logic [REQ_W-1:0] req, input logic [SAMPLE_W-1:0] smp,
			input logic [LAG_W-1:0] lag);
		logic [S_TDATA_W-1:0] d;
		d = '0;
		d[SAMPLE_W-1:0] = smp;
		d[SAMPLE_W+LAG_W-1:SAMPLE_W] = lag;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= S_TDATA_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= req;
		do @(posedge clk); while (!s_tready);
		shadow_step(req, smp, lag);
	endtask

	// count values biased toward the extremes
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(4))
			0: return '1;
			1: return '0;
			2: return SAMPLE_W'($urandom_range(15));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// receiver stalls at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// compare each output beat with the oldest owed read
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				$error("unexpected result beat: lag_index_out %0d accum_value %0h",
					m_tdata[LAG_W-1:0], m_tdata[LAG_W+ACC_W-1:LAG_W]);
				mismatch_count++;
			end else begin
				if (m_tdata[LAG_W-1:0] !== pending_reads[0].lag_index_out) begin
					$error("lag_index_out: expected %0d, actual %0d",
						pending_reads[0].lag_index_out, m_tdata[LAG_W-1:0]);
					mismatch_count++;
				end
				if (m_tdata[LAG_W+ACC_W-1:LAG_W] !== pending_reads[0].accum_value) begin
					$error("accum_value: expected %0h, actual %0h",
						pending_reads[0].accum_value, m_tdata[LAG_W+ACC_W-1:LAG_W]);
					mismatch_count++;
				end
				void'(pending_reads.pop_front());
			end
		end
	end

	// accumulators read straight after reset
	task automatic test_reset_state();
		send_beat(REQ_READ, '0, 3'd0);
		send_beat(REQ_READ, '1, 3'(NUM_LAGS - 1));
	endtask

	// first samples meet zeroed history, then full-scale and single-bit products
	task automatic test_early_samples();
		send_beat(REQ_PUSH, 16'hFFFF, 3'd7);
		send_beat(REQ_PUSH, 16'hFFFF, 3'd0);
		send_beat(REQ_PUSH, 16'h0000, 3'd5);
		send_beat(REQ_PUSH, 16'h8000, 3'd2);
		send_beat(REQ_PUSH, 16'h7FFF, 3'd1);
		send_beat(REQ_PUSH, 16'h0001, 3'd4);
		for (int l = 0; l < NUM_LAGS; l++)
			send_beat(REQ_READ, SAMPLE_W'($urandom), LAG_W'(l));
	endtask

	// lags past the last accumulator read as zero
	task automatic test_lag_range();
		for (int l = NUM_LAGS; l < 8; l++)
			send_beat(REQ_READ, 16'hFFFF, LAG_W'(l));
	endtask

	// the spare request code must leave the state alone
	task automatic test_unused_request();
		send_beat(REQ_UNUSED, 16'hFFFF, 3'd7);
		send_beat(REQ_READ, '0, 3'd0);
	endtask

	// clear wipes everything, whatever the other fields hold
	task automatic test_clear();
		send_beat(REQ_CLEAR, 16'hFFFF, 3'd7);
		send_beat(REQ_READ, '0, 3'd0);
		send_beat(REQ_READ, '0, 3'(NUM_LAGS - 1));
	endtask

	// mostly pushes and reads, rare clears, some spare-code noise
	task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
		int sent;
		int kind;
		logic [LAG_W-1:0] lag;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 58) begin
				send_beat(REQ_PUSH, pick_sample(), LAG_W'($urandom));
				sent++;
			end else if (kind < 91) begin
				if ($urandom_range(7) == 0)
					lag = LAG_W'($urandom);
				else
					lag = LAG_W'($urandom_range(NUM_LAGS - 1));
				send_beat(REQ_READ, SAMPLE_W'($urandom), lag);
				sent++;
			end else if (kind < 93) begin
				send_beat(REQ_CLEAR, SAMPLE_W'($urandom), LAG_W'($urandom));
				sent++;
			end else begin
				send_beat(REQ_UNUSED, SAMPLE_W'($urandom), LAG_W'($urandom));
				sent++;
			end
		end
	endtask

	// sender goes quiet until every read has come back, then resumes
	task automatic test_pause_until_drained();
		for (int i = 0; i < 6; i++)
			send_beat(REQ_PUSH, pick_sample(), LAG_W'($urandom));
		for (int l = 0; l < NUM_LAGS; l++)
			send_beat(REQ_READ, '0, LAG_W'(l));
		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (3 * NUM_LAGS) @(posedge clk);
		send_beat(REQ_PUSH, pick_sample(), '0);
		send_beat(REQ_READ, '0, 3'd0);
	endtask

	initial begin
		shadow_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_early_samples();
		test_lag_range();
		test_unused_request();
		test_clear();
		test_random_traffic(510, 20, 54);
		test_random_traffic(510, 54, 20);
		test_random_traffic(510, 0, 0);
		test_pause_until_drained();
		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (4 * NUM_LAGS) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
